// ===== sv/aes_pkg.sv =====
// Package for the AES-128 encrypt core: S-box, round constants and byte helpers.
// Used by the key expansion, the round cell and the top level.
package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned NumKeyWords = 44;

	typedef logic [127:0] block_t;
	typedef logic [31:0] word_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_index_t;

	function automatic logic [7:0] sbox(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
			8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
			8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
			8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
			8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
			8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
			8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
			8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
			8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
			8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
			8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
			8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
			8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
			8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
			8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
			8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
			8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
			8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
			8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
			8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
			8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
			8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
			8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
			8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
			8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
			8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
			8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
			8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
			8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
			8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
			8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
			8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
			8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
			8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
			8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
			8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
			8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
			8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
			8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
			8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
			8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
			8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
			8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
			8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
			8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
			8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
			8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
			8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
			8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
			8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
			8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
			8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
			8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Round constant for round 1..10 (index 0..9).
	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1B;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic word_t sub_word(input word_t w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

// ===== sv/aes_key_cell.sv =====
// One key-schedule cell: turns round key n-1 into round key n.
// Depends on aes_pkg (S-box, round constants).
module aes_key_cell
	import aes_pkg::*;
#(
	parameter logic [3:0] RoundIdx = 4'd0
) (
	input  block_t prev_key,
	output block_t next_key
);
	word_t t, w0, w1, w2, w3;

	always_comb begin
		t = sub_word({prev_key[23:0], prev_key[31:24]}) ^ {rcon(RoundIdx), 24'h000000};
		w0 = prev_key[127:96] ^ t;
		w1 = prev_key[95:64] ^ w0;
		w2 = prev_key[63:32] ^ w1;
		w3 = prev_key[31:0] ^ w2;
		next_key = {w0, w1, w2, w3};
	end
endmodule

// ===== sv/aes_round_cell.sv =====
// One round cell of the encrypt chain: SubBytes, ShiftRows, optional MixColumns,
// AddRoundKey, then a stage register. Depends on aes_pkg.
module aes_round_cell
	import aes_pkg::*;
#(
	parameter bit DoMix = 1'b1
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   in_vld,
	input  block_t in_state,
	input  block_t round_key,
	output logic   out_vld_q,
	output block_t out_state_q
);
	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	block_t nxt;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = in_state[127 - 8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			if (DoMix) begin
				m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
				m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
				m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
				m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
			end else begin
				for (int r = 0; r < 4; r++) begin
					m[4*c+r] = t[4*c+r];
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			nxt[127 - 8*i -: 8] = m[i];
		end
		nxt = nxt ^ round_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_state_q <= nxt;
		end
	end
endmodule

// ===== sv/aes128_block_encrypt_core.sv =====
// AES-128 ECB encrypt core: a chain of ten round cells, one block per beat.
// A block passes an input stage and then ten round stages from input beat to output beat.
// Throughput: one block per cycle; the whole chain advances unless the output is stalled.
// Reset clears all valid flags and the key registers to zero (the all-zero key); the
// registered round keys settle one cell per cycle, always ahead of the first block.
// Depends on aes_pkg, aes_key_cell and aes_round_cell.
module aes128_block_encrypt_core
	import aes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	// Key registers. Registers sit at 8-byte spacing, so paddr[3] is the index and
	// the low address bits are not decoded.
	logic [63:0] key_high_q, key_low_q;
	logic        wr_en;
	reg_index_t  wr_idx;

	assign pready = 1'b1;
	assign wr_idx = reg_index_t'(paddr[3]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LOW:  key_low_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_KEY_HIGH: prdata = key_high_q;
			REG_KEY_LOW:  prdata = key_low_q;
			default:      prdata = '0;
		endcase
	end

	// Round keys are expanded by a chain of key cells, each followed by a register
	// that loads every cycle. A key write reaches each round key before a block accepted
	// after the write reaches the round that uses it, so such a block always meets the
	// new keys.
	block_t rk [NumRounds + 1];
	assign rk[0] = {key_high_q, key_low_q};

	for (genvar g = 0; g < NumRounds; g++) begin : g_key
		block_t key_nxt;
		block_t key_q;

		aes_key_cell #(.RoundIdx(4'(g))) u_key (
			.prev_key(rk[g]),
			.next_key(key_nxt)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				key_q <= '0;
			end else begin
				key_q <= key_nxt;
			end
		end

		assign rk[g+1] = key_q;
	end

	// The whole pipeline moves when the final stage is empty or being taken.
	// Bubbles are not squeezed out; the output register is the last cell.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Input stage: initial AddRoundKey.
	logic   vld_s0;
	block_t st_s0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s0 <= {plain_high, plain_low} ^ rk[0];
		end
	end

	logic   vld [NumRounds + 1];
	block_t st  [NumRounds + 1];
	assign vld[0] = vld_s0;
	assign st[0]  = st_s0;

	// Round cells, each handing its state to the next every cycle that the chain advances.
	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		aes_round_cell #(.DoMix(g != NumRounds - 1)) u_round (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.in_vld     (vld[g]),
			.in_state   (st[g]),
			.round_key  (rk[g+1]),
			.out_vld_q  (vld[g+1]),
			.out_state_q(st[g+1])
		);
	end

	assign out_valid   = vld[NumRounds];
	assign cipher_high = st[NumRounds][127:64];
	assign cipher_low  = st[NumRounds][63:0];

	// A stalled result holds, the input stall follows the output stall, and a beat entering the last round is not lost.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("result changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall out of step with output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && vld[NumRounds - 1] |=> out_valid)
		else $error("beat lost at last round");
endmodule

// ===== tb/sv/aes128_block_encrypt_core_tb.sv =====
// Testbench for the AES-128 ECB encrypt core: directed and random plaintext blocks
// under several key settings, checked against an in-bench AES-128 predictor.
// Depends on aes_pkg and the aes128_block_encrypt_core RTL.
module aes128_block_encrypt_core_tb
	import aes_pkg::*;
;

	localparam int unsigned WatchdogLimit = 20000;
	localparam int unsigned DrainCycles = 40;
	// Register byte addresses: 64-bit registers, so register i lies at 8*i.
	localparam logic [3:0] AddrKeyHigh = 4'(8 * REG_KEY_HIGH);
	localparam logic [3:0] AddrKeyLow = 4'(8 * REG_KEY_LOW);

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] plain_high = '0;
	logic [63:0] plain_low = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	// Predictor state: the key registers and the expanded schedule.
	logic [63:0] model_key_high;
	logic [63:0] model_key_low;
	word_t model_round_keys [NumKeyWords];
	cipher_block_t pending_ciphers [$];

	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	// Idle and stall percentages applied by the driver and the output side.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	aes128_block_encrypt_core dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Our own tables: the S-box is computed from the field inverse and the affine map.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
		end
		return acc;
	endfunction

	function automatic logic [7:0] subst_byte(input logic [7:0] b);
		logic [7:0] inv;
		logic [7:0] y;
		inv = '0;
		for (int c = 1; c < 256; c++) begin
			if (gf_mul(b, 8'(c)) == 8'h01)
				inv = 8'(c);
		end
		for (int i = 0; i < 8; i++)
			y[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
				^ inv[(i + 7) % 8];
		return y ^ 8'h63;
	endfunction

	logic [7:0] sbox_table [256];

	function automatic word_t subst_word(input word_t w);
		return {sbox_table[w[31:24]], sbox_table[w[23:16]], sbox_table[w[15:8]],
			sbox_table[w[7:0]]};
	endfunction

	// Rebuilds the 44-word schedule from the current key halves.
	task automatic expand_model_key();
		word_t t;
		logic [7:0] round_const;
		round_const = 8'h01;
		model_round_keys[0] = model_key_high[63:32];
		model_round_keys[1] = model_key_high[31:0];
		model_round_keys[2] = model_key_low[63:32];
		model_round_keys[3] = model_key_low[31:0];
		for (int i = 4; i < NumKeyWords; i++) begin
			t = model_round_keys[i - 1];
			if (i % 4 == 0) begin
				t = subst_word({t[23:0], t[31:24]}) ^ {round_const, 24'h0};
				round_const = gf_mul(round_const, 8'h02);
			end
			model_round_keys[i] = model_round_keys[i - 4] ^ t;
		end
	endtask

	// Encrypts one block; state bytes are column-major, byte 0 in the top bits.
	function automatic cipher_block_t encrypt_block(input logic [127:0] plain);
		logic [7:0] st [16];
		logic [7:0] sh [16];
		logic [7:0] a0, a1, a2, a3;
		word_t w;
		for (int i = 0; i < 16; i++)
			st[i] = plain[127 - 8 * i -: 8];
		for (int rnd = 0; rnd <= NumRounds; rnd++) begin
			if (rnd > 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						sh[r + 4 * c] = sbox_table[st[r + 4 * ((c + r) % 4)]];
				for (int c = 0; c < 4; c++) begin
					a0 = sh[4 * c];
					a1 = sh[4 * c + 1];
					a2 = sh[4 * c + 2];
					a3 = sh[4 * c + 3];
					if (rnd == NumRounds) begin
						st[4 * c] = a0;
						st[4 * c + 1] = a1;
						st[4 * c + 2] = a2;
						st[4 * c + 3] = a3;
					end else begin
						st[4 * c] = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
						st[4 * c + 1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
						st[4 * c + 2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
						st[4 * c + 3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
					end
				end
			end
			for (int c = 0; c < 4; c++) begin
				w = model_round_keys[4 * rnd + c];
				for (int r = 0; r < 4; r++)
					st[r + 4 * c] ^= w[31 - 8 * r -: 8];
			end
		end
		for (int i = 0; i < 16; i++)
			encrypt_block[127 - 8 * i -: 8] = st[i];
	endfunction

	// One APB write: setup cycle, then access cycle; pready is always high.
	// The model follows only for the two key addresses.
	task automatic write_key_reg(input logic [3:0] addr, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == AddrKeyHigh) begin
			model_key_high = value;
			expand_model_key();
		end else if (addr == AddrKeyLow) begin
			model_key_low = value;
			expand_model_key();
		end
	endtask

	// Sends one plaintext beat, with an optional random gap before it.
	// The prediction is queued at the acceptance edge.
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		plain_high <= hi;
		plain_low <= lo;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_ciphers.push_back(encrypt_block({hi, lo}));
	endtask

	// Lowers valid and waits until every predicted block has come out,
	// then lets the pipeline settle before a key write.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_ciphers.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random plaintext, biased now and then to all-zero or all-one halves.
	function automatic logic [63:0] rand_half();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Every accepted output beat is compared with the oldest prediction.
	always @(posedge clk) begin
		cipher_block_t exp_block;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ciphers.size() == 0) begin
				$error("unexpected cipher beat %h %h", cipher_high, cipher_low);
				error_count++;
			end else begin
				exp_block = pending_ciphers.pop_front();
				if (cipher_high !== exp_block.hi) begin
					$error("cipher_high expected %h actual %h", exp_block.hi, cipher_high);
					error_count++;
				end
				if (cipher_low !== exp_block.lo) begin
					$error("cipher_low expected %h actual %h", exp_block.lo, cipher_low);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel nor the APB port moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The all-zero reset key, with the plaintext extremes and the FIPS-197 plaintext.
	task automatic test_reset_key();
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h8000_0000_0000_0000, '0);
		send_block('0, 64'h0000_0000_0000_0001);
		send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
		drain_pipeline();
	endtask

	// Known-answer vector with the FIPS-197 key, plus an all-ones key.
	task automatic test_known_keys();
		write_key_reg(AddrKeyHigh, 64'h0001_0203_0405_0607);
		write_key_reg(AddrKeyLow, 64'h0809_0a0b_0c0d_0e0f);
		send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
		send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		drain_pipeline();
		write_key_reg(AddrKeyHigh, '1);
		write_key_reg(AddrKeyLow, '1);
		send_block('0, '0);
		send_block('1, '1);
		drain_pipeline();
	endtask

	// Only one half rewritten: the other half of the old key must stay in use.
	task automatic test_half_key_update();
		write_key_reg(AddrKeyHigh, 64'h0123_4567_89ab_cdef);
		send_block(64'hdead_beef_0000_0000, 64'h0000_0000_feed_face);
		drain_pipeline();
		write_key_reg(AddrKeyLow, '0);
		send_block(64'hdead_beef_0000_0000, 64'h0000_0000_feed_face);
		drain_pipeline();
	endtask

	// Random blocks for one phase with the given idle and stall percentages, under a fresh key.
	task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_key_reg(AddrKeyHigh, rand_half());
		write_key_reg(AddrKeyLow, rand_half());
		for (int i = 0; i < count; i++)
			send_block(rand_half(), rand_half());
		drain_pipeline();
	endtask

	initial begin
		for (int i = 0; i < 256; i++)
			sbox_table[i] = subst_byte(8'(i));
		model_key_high = '0;
		model_key_low = '0;
		expand_model_key();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_known_keys();
		test_half_key_update();
		test_random_traffic(200, 0, 0);
		test_random_traffic(150, 82, 0);
		test_random_traffic(150, 0, 82);
		test_random_traffic(150, 27, 27);
		test_random_traffic(150, 0, 0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0 && pending_ciphers.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
